@@ src/gsmt_pkg.sv @@
// Shared types and constants for the grid shape mask test block.
package gsmt_pkg;

    localparam int unsigned COORD_W  = 24;
    localparam int unsigned UCOORD_W = 23;
    localparam int unsigned INDEX_W  = 10;
    localparam int unsigned COUNT_W  = 21;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned MUL_W    = 23;
    localparam int unsigned PROD_W   = 2 * MUL_W;
    localparam int unsigned OFF_W    = 36;
    localparam int unsigned ACC_W    = 94;
    localparam int unsigned LIMIT_W  = 13;

    localparam logic [COUNT_W-1:0] COUNT_CAP = 21'd1048576;

    localparam logic [CFG_IDX_W-1:0] REG_MASK_KIND = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_X    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_Y    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_EXTENT_X  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_EXTENT_Y  = 3'd6;

    localparam logic KIND_RECT    = 1'b0;
    localparam logic KIND_ELLIPSE = 1'b1;

    typedef struct packed {
        logic                       mask_kind;
        logic [UCOORD_W-1:0]        step_x;
        logic [UCOORD_W-1:0]        step_y;
        logic signed [COORD_W-1:0]  center_x;
        logic signed [COORD_W-1:0]  center_y;
        logic [UCOORD_W-1:0]        extent_x;
        logic [UCOORD_W-1:0]        extent_y;
    } cfg_t;

endpackage

@@ src/gsmt_ifs.sv @@
// Channel interfaces for cell items, result items and register writes.
interface gsmt_cell_in_if;
    logic       valid;
    logic       ready;
    logic [9:0] col_index;
    logic [9:0] row_index;
    logic       clear_count;

    modport source (output valid, output col_index, output row_index, output clear_count,
                    input ready);
    modport sink (input valid, input col_index, input row_index, input clear_count,
                  output ready);
endinterface

interface gsmt_cell_out_if;
    logic        valid;
    logic        ready;
    logic [9:0]  cell_col;
    logic [9:0]  cell_row;
    logic        inside_res;
    logic [20:0] inside_total;

    modport source (output valid, output cell_col, output cell_row, output inside_res,
                    output inside_total, input ready);
    modport sink (input valid, input cell_col, input cell_row, input inside_res,
                  input inside_total, output ready);
endinterface

interface gsmt_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [23:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ src/gsmt_cfg_regs.sv @@
// Configuration register file written through the register write channel.
module gsmt_cfg_regs
    import gsmt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    gsmt_cfg_if.sink   cfg,
    output cfg_t       cfg_q
);

    cfg_t cfg_reg;

    assign cfg.ready = 1'b1;
    assign cfg_q     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mask_kind <= KIND_RECT;
            cfg_reg.step_x    <= 23'd4096;
            cfg_reg.step_y    <= 23'd4096;
            cfg_reg.center_x  <= '0;
            cfg_reg.center_y  <= '0;
            cfg_reg.extent_x  <= 23'd4096;
            cfg_reg.extent_y  <= 23'd4096;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_MASK_KIND: cfg_reg.mask_kind <= cfg.data[0];
                REG_STEP_X:    cfg_reg.step_x    <= cfg.data[UCOORD_W-1:0];
                REG_STEP_Y:    cfg_reg.step_y    <= cfg.data[UCOORD_W-1:0];
                REG_CENTER_X:  cfg_reg.center_x  <= $signed(cfg.data);
                REG_CENTER_Y:  cfg_reg.center_y  <= $signed(cfg.data);
                REG_EXTENT_X:  cfg_reg.extent_x  <= cfg.data[UCOORD_W-1:0];
                REG_EXTENT_Y:  cfg_reg.extent_y  <= cfg.data[UCOORD_W-1:0];
                default:       cfg_reg <= cfg_reg;
            endcase
        end
    end

endmodule

@@ src/gsmt_mul.sv @@
// Shared unsigned 23 by 23 bit multiplier with a registered product.
module gsmt_mul
    import gsmt_pkg::*;
(
    input  logic              clk,
    input  logic [MUL_W-1:0]  op_a,
    input  logic [MUL_W-1:0]  op_b,
    output logic [PROD_W-1:0] prod
);

    logic [PROD_W-1:0] prod_reg;

    assign prod = prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
    end

endmodule

@@ src/gsmt_seq.sv @@
// Sequencer and datapath that test one cell at a time on the shared multiplier.
module gsmt_seq
    import gsmt_pkg::*;
#(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg_q,
    gsmt_cell_in_if.sink  cell_in,
    gsmt_cell_out_if.source cell_out
);

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_t;

    localparam logic [3:0] STEP_COL    = 4'd0;
    localparam logic [3:0] STEP_ROW    = 4'd1;
    localparam logic [3:0] STEP_EXT    = 4'd2;
    localparam logic [3:0] STEP_DECIDE = 4'd3;
    localparam logic [3:0] STEP_Q      = 4'd4;
    localparam logic [3:0] STEP_PHH    = 4'd5;
    localparam logic [3:0] STEP_PHL    = 4'd6;
    localparam logic [3:0] STEP_PLL    = 4'd7;
    localparam logic [3:0] STEP_QHH    = 4'd8;
    localparam logic [3:0] STEP_QHL    = 4'd9;
    localparam logic [3:0] STEP_QLL    = 4'd10;
    localparam logic [3:0] STEP_RHH    = 4'd11;
    localparam logic [3:0] STEP_RHL    = 4'd12;
    localparam logic [3:0] STEP_RLL    = 4'd13;
    localparam logic [3:0] STEP_LAST   = 4'd14;
    localparam logic [3:0] STEP_FINAL  = 4'd15;

    state_t                   state_reg;
    logic [3:0]               step_reg;
    logic [INDEX_W-1:0]       col_reg;
    logic [INDEX_W-1:0]       row_reg;
    logic                     clr_reg;
    logic [OFF_W-1:0]         ax2_reg;
    logic [OFF_W-1:0]         ay2_reg;
    logic [PROD_W-1:0]        p_reg;
    logic [PROD_W-1:0]        q_reg;
    logic [PROD_W-1:0]        r_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     inside_reg;
    logic [COUNT_W-1:0]       count_reg;
    logic                     out_valid_reg;
    logic [INDEX_W-1:0]       out_col_reg;
    logic [INDEX_W-1:0]       out_row_reg;
    logic                     out_inside_reg;

    logic [MUL_W-1:0]         op_a;
    logic [MUL_W-1:0]         op_b;
    logic [PROD_W-1:0]        prod;
    logic signed [COORD_W:0]  center_sel;
    logic signed [OFF_W-2:0]  diff;
    logic [OFF_W-2:0]         abs_diff;
    logic [OFF_W-1:0]         off2_next;
    logic signed [ACC_W-1:0]  term;
    logic signed [ACC_W-1:0]  acc_next;
    logic                     in_grid;
    logic                     ext_ok;
    logic                     rect_inside;
    logic                     box_reject;
    logic [COUNT_W-1:0]       count_base;
    logic [COUNT_W-1:0]       count_next;
    logic                     out_free;

    gsmt_mul u_mul (
        .clk  (clk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    always_comb
    begin
        case (step_reg)
            STEP_COL:
            begin
                op_a = MUL_W'(col_reg);
                op_b = cfg_q.step_x;
            end
            STEP_ROW:
            begin
                op_a = MUL_W'(row_reg);
                op_b = cfg_q.step_y;
            end
            STEP_EXT:
            begin
                op_a = cfg_q.extent_x;
                op_b = cfg_q.extent_y;
            end
            STEP_DECIDE:
            begin
                op_a = ax2_reg[MUL_W-1:0];
                op_b = cfg_q.extent_y;
            end
            STEP_Q:
            begin
                op_a = ay2_reg[MUL_W-1:0];
                op_b = cfg_q.extent_x;
            end
            STEP_PHH:
            begin
                op_a = p_reg[PROD_W-1:MUL_W];
                op_b = p_reg[PROD_W-1:MUL_W];
            end
            STEP_PHL:
            begin
                op_a = p_reg[PROD_W-1:MUL_W];
                op_b = p_reg[MUL_W-1:0];
            end
            STEP_PLL:
            begin
                op_a = p_reg[MUL_W-1:0];
                op_b = p_reg[MUL_W-1:0];
            end
            STEP_QHH:
            begin
                op_a = q_reg[PROD_W-1:MUL_W];
                op_b = q_reg[PROD_W-1:MUL_W];
            end
            STEP_QHL:
            begin
                op_a = q_reg[PROD_W-1:MUL_W];
                op_b = q_reg[MUL_W-1:0];
            end
            STEP_QLL:
            begin
                op_a = q_reg[MUL_W-1:0];
                op_b = q_reg[MUL_W-1:0];
            end
            STEP_RHH:
            begin
                op_a = r_reg[PROD_W-1:MUL_W];
                op_b = r_reg[PROD_W-1:MUL_W];
            end
            STEP_RHL:
            begin
                op_a = r_reg[PROD_W-1:MUL_W];
                op_b = r_reg[MUL_W-1:0];
            end
            STEP_RLL:
            begin
                op_a = r_reg[MUL_W-1:0];
                op_b = r_reg[MUL_W-1:0];
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // The cell position is the product from the previous step; the doubled
    // absolute offset from the centre is formed here.
    always_comb
    begin
        if (step_reg == STEP_ROW)
        begin
            center_sel = (COORD_W + 1)'(cfg_q.center_x);
        end
        else
        begin
            center_sel = (COORD_W + 1)'(cfg_q.center_y);
        end
        diff      = $signed({2'b00, prod[32:0]}) - (OFF_W - 1)'(center_sel);
        abs_diff  = diff[OFF_W-2] ? (OFF_W - 1)'(-diff) : (OFF_W - 1)'(diff);
        off2_next = {abs_diff, 1'b0};
    end

    // Accumulates p^2 + q^2 - r^2 from the split partial products. The
    // product seen in each step is the one issued in the step before.
    always_comb
    begin
        case (step_reg)
            STEP_PHL, STEP_QHL, STEP_RHL:
            begin
                term = $signed(ACC_W'(prod) << (2 * MUL_W));
            end
            STEP_PLL, STEP_QLL, STEP_RLL:
            begin
                term = $signed(ACC_W'(prod) << (MUL_W + 1));
            end
            STEP_QHH, STEP_RHH, STEP_LAST:
            begin
                term = $signed(ACC_W'(prod));
            end
            default:
            begin
                term = '0;
            end
        endcase
        if (step_reg == STEP_RLL || step_reg == STEP_LAST || step_reg == STEP_RHL)
        begin
            acc_next = acc_reg - term;
        end
        else
        begin
            acc_next = acc_reg + term;
        end
    end

    always_comb
    begin
        in_grid     = ({3'b000, col_reg} < LIMIT_W'(MAX_COLS))
                      && ({3'b000, row_reg} < LIMIT_W'(MAX_ROWS));
        ext_ok      = (cfg_q.extent_x != '0) && (cfg_q.extent_y != '0);
        rect_inside = in_grid && (ax2_reg < OFF_W'(cfg_q.extent_x))
                      && (ay2_reg < OFF_W'(cfg_q.extent_y));
        box_reject  = !in_grid || !ext_ok || (ax2_reg > OFF_W'(cfg_q.extent_x))
                      || (ay2_reg > OFF_W'(cfg_q.extent_y));
        count_base  = clr_reg ? '0 : count_reg;
        if (inside_reg && (count_base < COUNT_CAP))
        begin
            count_next = count_base + COUNT_W'(1);
        end
        else
        begin
            count_next = count_base;
        end
        out_free = !out_valid_reg || cell_out.ready;
    end

    assign cell_in.ready         = (state_reg == ST_IDLE);
    assign cell_out.valid        = out_valid_reg;
    assign cell_out.cell_col     = out_col_reg;
    assign cell_out.cell_row     = out_row_reg;
    assign cell_out.inside_res   = out_inside_reg;
    assign cell_out.inside_total = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= STEP_COL;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            col_reg        <= '0;
            row_reg        <= '0;
            clr_reg        <= 1'b0;
            ax2_reg        <= '0;
            ay2_reg        <= '0;
            p_reg          <= '0;
            q_reg          <= '0;
            r_reg          <= '0;
            acc_reg        <= '0;
            inside_reg     <= 1'b0;
            out_col_reg    <= '0;
            out_row_reg    <= '0;
            out_inside_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && cell_out.ready && (state_reg != ST_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (cell_in.valid)
                    begin
                        col_reg   <= cell_in.col_index;
                        row_reg   <= cell_in.row_index;
                        clr_reg   <= cell_in.clear_count;
                        acc_reg   <= '0;
                        step_reg  <= STEP_COL;
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    step_reg <= step_reg + 4'd1;
                    acc_reg  <= acc_next;
                    case (step_reg)
                        STEP_ROW:
                        begin
                            ax2_reg <= off2_next;
                        end
                        STEP_EXT:
                        begin
                            ay2_reg <= off2_next;
                        end
                        STEP_DECIDE:
                        begin
                            r_reg <= prod;
                            if (cfg_q.mask_kind == KIND_RECT)
                            begin
                                inside_reg <= rect_inside;
                                state_reg  <= ST_DONE;
                            end
                            else if (box_reject)
                            begin
                                inside_reg <= 1'b0;
                                state_reg  <= ST_DONE;
                            end
                        end
                        STEP_Q:
                        begin
                            p_reg <= prod;
                        end
                        STEP_PHH:
                        begin
                            q_reg <= prod;
                        end
                        STEP_FINAL:
                        begin
                            inside_reg <= acc_reg[ACC_W-1] || (acc_reg == '0);
                            state_reg  <= ST_DONE;
                        end
                        default:
                        begin
                            p_reg <= p_reg;
                        end
                    endcase
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_col_reg    <= col_reg;
                        out_row_reg    <= row_reg;
                        out_inside_reg <= inside_reg;
                        count_reg      <= count_next;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

@@ src/grid_shape_mask_test.sv @@
// Top level of the grid shape mask test block.
// Each accepted cell is placed at column times step_x and row times step_y,
// offset from the configured centre and tested against a rectangle or an
// ellipse; the result carries the cell indices, the inside bit and a running
// inside count that saturates at 1048576. Cells are handled one at a time on
// a single registered 23 by 23 bit multiplier stepped by a sequencer: a
// rectangle test, and an ellipse test that falls outside the bounding box,
// end at the decide step, and a full ellipse test runs on to the final step,
// since the exact 92-bit comparison is built from nine partial squares on
// that multiplier. The input is ready again in the cycle after the result
// register is loaded; a result held back by the sink holds the next cell in
// its last step. Registers are to be written only while the block is idle,
// which the block itself does not enforce; they take effect on the next cell.
module grid_shape_mask_test
    import gsmt_pkg::*;
#(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
)
(
    input  logic             clk,
    input  logic             rst_n,
    gsmt_cfg_if.sink         cfg,
    gsmt_cell_in_if.sink     cell_in,
    gsmt_cell_out_if.source  cell_out
);

    cfg_t cfg_q;

    gsmt_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    gsmt_seq #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_q    (cfg_q),
        .cell_in  (cell_in),
        .cell_out (cell_out)
    );

endmodule

@@ sim/grid_shape_mask_test_test.sv @@
// Self-checking testbench for the grid shape mask block with random stimulus and stalls.
module grid_shape_mask_test_test;
    import gsmt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [INDEX_W-1:0] col;
        logic [INDEX_W-1:0] row;
        logic               clear;
    } cell_req_t;

    typedef struct {
        logic [INDEX_W-1:0] col;
        logic [INDEX_W-1:0] row;
        logic               hit;
        logic [COUNT_W-1:0] total;
    } cell_result_t;

    logic clk;
    logic rst_n;

    gsmt_cfg_if      cfg_ch ();
    gsmt_cell_in_if  cell_in_ch ();
    gsmt_cell_out_if cell_out_ch ();

    grid_shape_mask_test dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_ch),
        .cell_in  (cell_in_ch),
        .cell_out (cell_out_ch)
    );

    cfg_t               mask_cfg;
    logic [COUNT_W-1:0] hit_count;
    cell_req_t          pending_cells[$];
    cell_result_t       expected_cells[$];
    int                 cells_queued;
    int                 cells_taken;
    int                 mismatches;
    int                 send_idle;
    int                 recv_idle;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic shape_hit(input logic [INDEX_W-1:0] col, input logic [INDEX_W-1:0] row);
        longint     dx;
        longint     dy;
        longint     ax2;
        longint     ay2;
        bit [127:0] ax;
        bit [127:0] ay;
        bit [127:0] ex;
        bit [127:0] ey;
        if (mask_cfg.extent_x == 0 || mask_cfg.extent_y == 0)
        begin
            return 1'b0;
        end
        dx = longint'(col) * longint'(mask_cfg.step_x) - longint'($signed(mask_cfg.center_x));
        dy = longint'(row) * longint'(mask_cfg.step_y) - longint'($signed(mask_cfg.center_y));
        ax2 = 2 * (dx < 0 ? -dx : dx);
        ay2 = 2 * (dy < 0 ? -dy : dy);
        if (mask_cfg.mask_kind == KIND_RECT)
        begin
            return ax2 < longint'(mask_cfg.extent_x) && ay2 < longint'(mask_cfg.extent_y);
        end
        if (ax2 > longint'(mask_cfg.extent_x) || ay2 > longint'(mask_cfg.extent_y))
        begin
            return 1'b0;
        end
        ax = ax2;
        ay = ay2;
        ex = mask_cfg.extent_x;
        ey = mask_cfg.extent_y;
        return ax * ax * ey * ey + ay * ay * ex * ex <= ex * ex * ey * ey;
    endfunction

    always @(posedge clk)
    begin
        cell_req_t    req;
        cell_result_t res;
        if (!rst_n)
        begin
            cell_in_ch.valid <= 1'b0;
        end
        else
        begin
            if (cell_in_ch.valid && cell_in_ch.ready)
            begin
                if (cell_in_ch.clear_count)
                begin
                    hit_count = '0;
                end
                res.col   = cell_in_ch.col_index;
                res.row   = cell_in_ch.row_index;
                res.hit   = shape_hit(cell_in_ch.col_index, cell_in_ch.row_index);
                if (res.hit && hit_count < COUNT_CAP)
                begin
                    hit_count = hit_count + 1'b1;
                end
                res.total = hit_count;
                expected_cells.push_back(res);
                cells_taken++;
            end
            if (!cell_in_ch.valid || cell_in_ch.ready)
            begin
                if (pending_cells.size() > 0 && $urandom_range(0, 99) >= send_idle)
                begin
                    req = pending_cells.pop_front();
                    cell_in_ch.valid       <= 1'b1;
                    cell_in_ch.col_index   <= req.col;
                    cell_in_ch.row_index   <= req.row;
                    cell_in_ch.clear_count <= req.clear;
                end
                else
                begin
                    cell_in_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cell_result_t exp_res;
        if (!rst_n)
        begin
            cell_out_ch.ready <= 1'b0;
        end
        else
        begin
            if (cell_out_ch.valid && cell_out_ch.ready)
            begin
                if (expected_cells.size() == 0)
                begin
                    if (mismatches < 40)
                    begin
                        $display("%0t: unexpected result col %0d row %0d inside %0d total %0d",
                                 $time, cell_out_ch.cell_col, cell_out_ch.cell_row,
                                 cell_out_ch.inside_res, cell_out_ch.inside_total);
                    end
                    mismatches++;
                end
                else
                begin
                    exp_res = expected_cells.pop_front();
                    if (cell_out_ch.cell_col !== exp_res.col
                        || cell_out_ch.cell_row !== exp_res.row
                        || cell_out_ch.inside_res !== exp_res.hit
                        || cell_out_ch.inside_total !== exp_res.total)
                    begin
                        if (mismatches < 40)
                        begin
                            $display({"%0t: mismatch expected col %0d row %0d inside %0d ",
                                      "total %0d, actual col %0d row %0d inside %0d total %0d"},
                                     $time, exp_res.col, exp_res.row, exp_res.hit,
                                     exp_res.total, cell_out_ch.cell_col, cell_out_ch.cell_row,
                                     cell_out_ch.inside_res, cell_out_ch.inside_total);
                        end
                        mismatches++;
                    end
                end
            end
            cell_out_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    task automatic add_cell(input int col, input int row, input logic clear);
        cell_req_t req;
        req.col   = col;
        req.row   = row;
        req.clear = clear;
        pending_cells.push_back(req);
        cells_queued++;
    endtask

    task automatic drain();
        do
        begin
            @(posedge clk);
        end
        while (!(cells_taken == cells_queued && expected_cells.size() == 0));
    endtask

    task automatic set_mask(input logic kind, input logic [22:0] sx, input logic [22:0] sy,
                            input logic signed [23:0] cx, input logic signed [23:0] cy,
                            input logic [22:0] ex, input logic [22:0] ey);
        logic [CFG_IDX_W-1:0] idxs [7];
        logic [23:0]          vals [7];
        idxs = '{REG_MASK_KIND, REG_STEP_X, REG_STEP_Y, REG_CENTER_X, REG_CENTER_Y,
                 REG_EXTENT_X, REG_EXTENT_Y};
        vals = '{{23'd0, kind}, {1'b0, sx}, {1'b0, sy}, cx, cy, {1'b0, ex}, {1'b0, ey}};
        for (int i = 0; i < 7; i++)
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idxs[i];
            cfg_ch.data  <= vals[i];
            @(posedge clk);
            while (!cfg_ch.ready)
            begin
                @(posedge clk);
            end
            case (idxs[i])
                REG_MASK_KIND: mask_cfg.mask_kind = vals[i][0];
                REG_STEP_X:    mask_cfg.step_x    = vals[i][22:0];
                REG_STEP_Y:    mask_cfg.step_y    = vals[i][22:0];
                REG_CENTER_X:  mask_cfg.center_x  = vals[i];
                REG_CENTER_Y:  mask_cfg.center_y  = vals[i];
                REG_EXTENT_X:  mask_cfg.extent_x  = vals[i][22:0];
                REG_EXTENT_Y:  mask_cfg.extent_y  = vals[i][22:0];
                default:       ;
            endcase
        end
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic pick_axis(output logic [22:0] stp, output logic signed [23:0] ctr,
                             output logic [22:0] ext, output int aim, output int span);
        longint s;
        longint c;
        longint e;
        case ($urandom_range(0, 9))
            0:       s = 0;
            1:       s = 1;
            2:       s = 8388607;
            default: s = $urandom_range(64, 32768);
        endcase
        aim = $urandom_range(0, 1023);
        c = aim * s + longint'($urandom_range(0, 2 * s)) - s;
        if (c > 8388607)
        begin
            c = 8388607;
        end
        if (c < -8388608)
        begin
            c = -8388608;
        end
        case ($urandom_range(0, 9))
            0:       e = 8388607;
            1:       e = $urandom_range(0, 16);
            default: e = s * $urandom_range(1, 30) + $urandom_range(0, s);
        endcase
        if (e > 8388607)
        begin
            e = 8388607;
        end
        span = (s == 0) ? 1023 : int'(e / s / 2 + 2);
        if (span > 1023)
        begin
            span = 1023;
        end
        stp = s;
        ctr = c;
        ext = e;
    endtask

    function automatic int near_index(input int aim, input int span);
        int v;
        v = aim + int'($urandom_range(0, 2 * span)) - span;
        if (v < 0)
        begin
            v = 0;
        end
        if (v > 1023)
        begin
            v = 1023;
        end
        return v;
    endfunction

    initial
    begin
        logic [22:0]        sx;
        logic [22:0]        sy;
        logic [22:0]        ex;
        logic [22:0]        ey;
        logic signed [23:0] cx;
        logic signed [23:0] cy;
        int                 aim_col;
        int                 aim_row;
        int                 span_col;
        int                 span_row;
        rst_n = 1'b0;
        clk   = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data  = '0;
        cell_in_ch.valid       = 1'b0;
        cell_in_ch.col_index   = '0;
        cell_in_ch.row_index   = '0;
        cell_in_ch.clear_count = 1'b0;
        cell_out_ch.ready = 1'b0;
        mask_cfg = '{mask_kind: KIND_RECT, step_x: 23'd4096, step_y: 23'd4096,
                     center_x: 24'sd0, center_y: 24'sd0,
                     extent_x: 23'd4096, extent_y: 23'd4096};
        hit_count    = '0;
        cells_queued = 0;
        cells_taken  = 0;
        mismatches   = 0;
        send_idle    = 19;
        recv_idle    = 65;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_cell(0, 0, 1'b1);
        add_cell(0, 0, 1'b0);
        add_cell(1023, 1023, 1'b0);
        add_cell(1023, 0, 1'b0);
        add_cell(0, 1023, 1'b0);
        add_cell(10'h2AA, 10'h155, 1'b1);
        add_cell(10'h155, 10'h2AA, 1'b0);
        add_cell(0, 0, 1'b0);
        drain();

        // Ellipse of radius four cells: boundary cells on both axes, a diagonal pair.
        set_mask(KIND_ELLIPSE, 23'd4096, 23'd4096, 24'sd20480, 24'sd20480,
                 23'd32768, 23'd32768);
        add_cell(1, 5, 1'b0);
        add_cell(9, 5, 1'b0);
        add_cell(10, 5, 1'b0);
        add_cell(5, 1, 1'b0);
        add_cell(7, 8, 1'b0);
        add_cell(8, 8, 1'b0);
        add_cell(5, 5, 1'b0);
        drain();

        set_mask(KIND_RECT, 23'h7FFFFF, 23'h7FFFFF, -24'sd8388608, 24'sd8388607,
                 23'h7FFFFF, 23'h7FFFFF);
        add_cell(0, 0, 1'b0);
        add_cell(0, 1, 1'b0);
        add_cell(1, 1, 1'b0);
        add_cell(1023, 1023, 1'b0);
        drain();

        // A zero width gives no inside cell whatever the other settings.
        set_mask(KIND_ELLIPSE, 23'd0, 23'd1, 24'sd0, 24'sd8388607, 23'd0, 23'h7FFFFF);
        add_cell(0, 0, 1'b0);
        add_cell(1023, 1023, 1'b0);
        drain();

        set_mask(KIND_ELLIPSE, 23'd0, 23'd1, -24'sd8388608, 24'sd8388607,
                 23'h7FFFFF, 23'h7FFFFF);
        add_cell(1023, 1023, 1'b0);
        add_cell(0, 0, 1'b0);
        add_cell(1023, 0, 1'b0);
        drain();

        for (int seg = 0; seg < 9; seg++)
        begin
            if (seg < 3)
            begin
                send_idle = 19;
                recv_idle = 65;
            end
            else if (seg < 6)
            begin
                send_idle = 65;
                recv_idle = 19;
            end
            else
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            pick_axis(sx, cx, ex, aim_col, span_col);
            pick_axis(sy, cy, ey, aim_row, span_row);
            set_mask(logic'($urandom_range(0, 1)), sx, sy, cx, cy, ex, ey);
            for (int n = 0; n < 95; n++)
            begin
                if ($urandom_range(0, 99) < 80)
                begin
                    add_cell(near_index(aim_col, span_col), near_index(aim_row, span_row),
                             logic'($urandom_range(0, 99) < 3));
                end
                else
                begin
                    add_cell($urandom_range(0, 1023), $urandom_range(0, 1023),
                             logic'($urandom_range(0, 99) < 3));
                end
            end
            drain();
        end

        repeat (40) @(posedge clk);
        if (mismatches == 0 && expected_cells.size() == 0)
        begin
            $display("grid_shape_mask_test test passed");
        end
        else
        begin
            $display("grid_shape_mask_test test failed");
        end
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("grid_shape_mask_test test failed");
        $finish;
    end

endmodule
